@@ sv/keyed_session_table_macros.svh @@
// assertion macros for the keyed session table
`ifndef KEYED_SESSION_TABLE_MACROS_SVH
`define KEYED_SESSION_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define KST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("keyed_session_table: check failed");

// expression must never be true outside reset
`define KST_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("keyed_session_table: forbidden condition");

`else

`define KST_ASSERT(lbl, prop)
`define KST_NEVER(lbl, expr)

`endif

`endif

@@ sv/ksess_pkg.sv @@
// shared types and constants for the keyed session table
package ksess_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned KEY_CHARS = 19;
  localparam int unsigned KEY_W     = 152;
  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // per-cell control from the table sequencer
  typedef struct packed {
    logic live;      // cell index below the entry count
    logic cmp_en;    // capture the key compare result
    logic write_en;  // load the new entry
    logic shift_en;  // take the entry of the upper neighbor
  } cell_ctrl_t;

endpackage

@@ sv/ksess_cell.sv @@
// one table cell: stored key and handle, key compare, shift from neighbor
module ksess_cell import ksess_pkg::*; (
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [KEY_W-1:0]    nb_key_i,
  input  logic [HANDLE_W-1:0] nb_handle_i,
  output logic [KEY_W-1:0]    key_o,
  output logic [HANDLE_W-1:0] handle_o,
  output logic                hit_o
);

  logic [KEY_W-1:0]    key_q, key_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic                hit_q, hit_d;

  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (ctrl_i.write_en) begin
      key_d    = key_i;
      handle_d = handle_i;
    end else if (ctrl_i.shift_en) begin
      key_d    = nb_key_i;
      handle_d = nb_handle_i;
    end
    hit_d = hit_q;
    if (ctrl_i.cmp_en) begin
      hit_d = ctrl_i.live && (key_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
    hit_q    <= hit_d;
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;
  assign hit_o    = hit_q;

endmodule

@@ sv/keyed_session_table.sv @@
// keyed session table: ordered key/handle table built as a row of cells
//
//   channel  dir  fields (lsb first)
//   s_axis   in   opcode, key_low, key_mid, key_high, conn_handle
//   m_axis   out  status, slot_index, found_handle, entry_count
//
// an operation runs a compare state (parallel key compare in all cells), then
// an update state (priority pick, table append or shift down by one). a new
// transfer is also taken in the update state, so the next operation starts as
// the last ends. the result sits in an output register; when it is not taken,
// the update state waits. reset clears the count and control only.
`include "keyed_session_table_macros.svh"

module keyed_session_table import ksess_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // opcode, key_low, key_mid, key_high, conn_handle, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, slot_index, found_handle, entry_count, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // zero everything from the first nul character on
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    logic             alive;
    res   = '0;
    alive = 1'b1;
    for (int c = 0; c < KEY_W / 8; c++) begin
      if (raw[8*c +: 8] == 8'd0 || c >= KEY_CHARS) alive = 1'b0;
      if (alive) res[8*c +: 8] = raw[8*c +: 8];
    end
    return res;
  endfunction

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [OPCODE_W-1:0]   op_q;
  logic [KEY_W-1:0]      key_q;
  logic [HANDLE_W-1:0]   handle_q;
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic                  in_xfer, exe_go;
  logic [DEPTH-1:0]      hit_vec;
  logic [IdxW-1:0]       pos;
  logic                  any_hit;
  logic [HANDLE_W-1:0]   sel_handle;
  logic                  ins_ok, rem_ok;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_W-1:0]     slot;
  logic [HANDLE_W-1:0]   found_handle;

  cell_ctrl_t            ctrl [DEPTH];
  logic [KEY_W-1:0]      cell_key [DEPTH];
  logic [HANDLE_W-1:0]   cell_handle [DEPTH];

  assign exe_go        = (state_q == S_EXEC) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == S_IDLE) || exe_go;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q     <= s_axis_tdata[1:0];
      key_q    <= norm_key(s_axis_tdata[153:2]);
      handle_q <= s_axis_tdata[169:154];
    end
  end

  // the row of cells; the top cell feeds itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]    nb_key;
    logic [HANDLE_W-1:0] nb_handle;

    if (i == DEPTH - 1) begin : g_top
      assign nb_key    = cell_key[i];
      assign nb_handle = cell_handle[i];
    end else begin : g_mid
      assign nb_key    = cell_key[i+1];
      assign nb_handle = cell_handle[i+1];
    end

    always_comb begin
      ctrl[i].live     = CntW'(i) < count_q;
      ctrl[i].cmp_en   = (state_q == S_CMP);
      ctrl[i].write_en = exe_go && ins_ok && (count_q == CntW'(i));
      ctrl[i].shift_en = exe_go && rem_ok && (IdxW'(i) >= pos);
    end

    ksess_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[i]),
      .key_i       (key_q),
      .handle_i    (handle_q),
      .nb_key_i    (nb_key),
      .nb_handle_i (nb_handle),
      .key_o       (cell_key[i]),
      .handle_o    (cell_handle[i]),
      .hit_o       (hit_vec[i])
    );
  end

  // first hit and its handle
  always_comb begin
    pos        = '0;
    sel_handle = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) pos = IdxW'(i);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i] && (pos == IdxW'(i))) sel_handle = cell_handle[i];
    end
    any_hit = |hit_vec;
  end

  always_comb begin
    ins_ok       = 1'b0;
    rem_ok       = 1'b0;
    status       = ST_MISS;
    slot         = '0;
    found_handle = '0;
    count_d      = count_q;
    case (op_q)
      OP_INSERT: begin
        if (count_q >= CntW'(DEPTH)) begin
          status = ST_FULL;
        end else if (any_hit) begin
          status = ST_DUP;
          slot   = SLOT_W'(pos);
        end else begin
          status  = ST_OK;
          ins_ok  = 1'b1;
          slot    = SLOT_W'(count_q);
          count_d = count_q + CntW'(1);
        end
      end
      OP_FIND: begin
        if (any_hit) begin
          status       = ST_OK;
          slot         = SLOT_W'(pos);
          found_handle = sel_handle;
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          status  = ST_OK;
          rem_ok  = 1'b1;
          slot    = SLOT_W'(pos);
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
        status = ST_MISS;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_CMP;
      S_CMP:  state_d = S_EXEC;
      S_EXEC: begin
        if (exe_go) state_d = in_xfer ? S_CMP : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    if (exe_go) begin
      m_valid_d = 1'b1;
      m_data_d  = {1'b0, COUNT_W'(count_d), found_handle, slot, status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= exe_go ? count_d : count_q;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // live keys are unique, so at most one cell can match
  `KST_ASSERT(a_single_hit, (state_q == S_EXEC) |-> $onehot0(hit_vec))
  `KST_NEVER(a_count_range, count_q > CntW'(DEPTH))
  `KST_ASSERT(a_cmp_then_exec, (state_q == S_CMP) |=> (state_q == S_EXEC))
  `KST_ASSERT(a_count_only_on_exec, !$stable(count_q) |-> $past(exe_go))

endmodule
